// File: hdl/bma_pkg.sv
// ----------------------------------------------------------------------------
// bma_pkg
// Shared types and constants for the boxcar moving average core.
// ----------------------------------------------------------------------------
package bma_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 9;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ACC,
        S_DLOAD,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic shift;
    } t_acc_ctl;

    typedef struct packed {
        logic load;
        logic shift;
    } t_div_ctl;

endpackage

// File: hdl/boxcar_moving_average_core.sv
// ----------------------------------------------------------------------------
// boxcar_moving_average_core
// Moving average of the last L signed 16-bit samples, truncated toward zero.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_sample_in) carries one sample
//   per transaction; output channel (o_out_valid / i_out_ready /
//   o_average_out) returns exactly one average per sample, in order.
//   Config channel (i_cfg_valid / o_cfg_ready / i_window_length) sets L,
//   clamped to 1..MAX_LENGTH, and clears history and running sum. Write it
//   only while no sample is in flight.
//   Each sample passes the bit-serial sum pass and then the serial divider,
//   each working bit by bit over the SUM_W-bit sum. One sample is
//   processed at a time: the next is taken only once the divider has
//   moved its result into the output register.
//   The finished result sits in an output register; the next sample is
//   accepted while it waits. If the receiver stalls, the next result holds
//   in the divider until the output register frees up.
//   Reset: L = 1, history and sum cleared; no clearing pass is needed.
// ----------------------------------------------------------------------------
module boxcar_moving_average_core #(
    parameter int MAX_LENGTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [bma_pkg::SAMPLE_W-1:0]   i_sample_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [bma_pkg::SAMPLE_W-1:0]   o_average_out,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [bma_pkg::CFG_W-1:0]             i_window_length
);

    localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
    localparam int SLOT_W = $clog2(MAX_LENGTH);
    localparam int SUM_W  = bma_pkg::SAMPLE_W + $clog2(MAX_LENGTH) + 1;
    localparam int CNT_W  = $clog2(SUM_W);

    bma_pkg::t_state   r_state;
    bma_pkg::t_state   n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [LEN_W-1:0]  r_len;
    logic signed [bma_pkg::SAMPLE_W-1:0] r_sample;
    logic              r_out_valid;
    logic signed [bma_pkg::SAMPLE_W-1:0] r_out_data;

    logic              cfg_wr;
    logic              in_acc;
    logic              out_load;
    logic              cnt_last;
    bma_pkg::t_acc_ctl acc_ctl;
    bma_pkg::t_div_ctl div_ctl;
    logic signed [bma_pkg::SAMPLE_W-1:0] old_sample;
    logic [SUM_W-1:0]  mag;
    logic              sign;
    logic signed [bma_pkg::SAMPLE_W-1:0] div_result;

    assign o_cfg_ready = i_rst_n;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;
    assign in_acc      = i_in_valid & o_in_ready;
    assign cnt_last    = (r_cnt == CNT_W'(SUM_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(1);
        end else if (cfg_wr) begin
            if (i_window_length == '0) begin
                r_len <= LEN_W'(1);
            end else if (32'(i_window_length) > 32'(MAX_LENGTH)) begin
                r_len <= LEN_W'(MAX_LENGTH);
            end else begin
                r_len <= LEN_W'(i_window_length);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= i_sample_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bma_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        o_in_ready    = 1'b0;
        out_load      = 1'b0;
        acc_ctl.clear = cfg_wr;
        acc_ctl.load  = 1'b0;
        acc_ctl.shift = 1'b0;
        div_ctl.load  = 1'b0;
        div_ctl.shift = 1'b0;
        case (r_state)
            bma_pkg::S_IDLE: begin
                o_in_ready = i_rst_n;
                if (in_acc) begin
                    n_state = bma_pkg::S_READ;
                end
            end
            bma_pkg::S_READ: begin
                acc_ctl.load = 1'b1;
                n_cnt        = '0;
                n_state      = bma_pkg::S_ACC;
            end
            bma_pkg::S_ACC: begin
                acc_ctl.shift = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_state = bma_pkg::S_DLOAD;
                end
            end
            bma_pkg::S_DLOAD: begin
                div_ctl.load = 1'b1;
                n_cnt        = '0;
                n_state      = bma_pkg::S_DIV;
            end
            bma_pkg::S_DIV: begin
                div_ctl.shift = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (cnt_last) begin
                    n_state = bma_pkg::S_OUT;
                end
            end
            bma_pkg::S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = bma_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bma_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= div_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_average_out = r_out_data;

    bma_history #(
        .MAX_LENGTH (MAX_LENGTH),
        .LEN_W      (LEN_W),
        .SLOT_W     (SLOT_W)
    ) u_history (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (cfg_wr),
        .i_len   (r_len),
        .i_we    (in_acc),
        .i_wdata (i_sample_in),
        .o_old   (old_sample)
    );

    bma_acc #(
        .SUM_W (SUM_W)
    ) u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (acc_ctl),
        .i_new   (r_sample),
        .i_old   (old_sample),
        .o_mag   (mag),
        .o_sign  (sign)
    );

    bma_div #(
        .SUM_W (SUM_W),
        .LEN_W (LEN_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_ctl    (div_ctl),
        .i_mag    (mag),
        .i_sign   (sign),
        .i_len    (r_len),
        .o_result (div_result)
    );

endmodule

// File: hdl/bma_history.sv
// ----------------------------------------------------------------------------
// bma_history
// Sample history memory with write slot and wrap flag; slots not written
// since the last clear read as zero.
// ----------------------------------------------------------------------------
module bma_history #(
    parameter int MAX_LENGTH = 256,
    parameter int LEN_W      = 9,
    parameter int SLOT_W     = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_clear,
    input  logic [LEN_W-1:0]                      i_len,
    input  logic                                  i_we,
    input  logic signed [bma_pkg::SAMPLE_W-1:0]   i_wdata,
    output logic signed [bma_pkg::SAMPLE_W-1:0]   o_old
);

    logic signed [bma_pkg::SAMPLE_W-1:0] r_mem [MAX_LENGTH];
    logic signed [bma_pkg::SAMPLE_W-1:0] r_rd_data;
    logic [SLOT_W-1:0]                   r_slot;
    logic [SLOT_W-1:0]                   n_slot;
    logic                                r_wrapped;
    logic                                n_wrapped;
    logic                                r_rd_live;
    logic                                last_slot;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[r_slot] <= i_wdata;
            r_rd_data     <= r_mem[r_slot];
        end
    end

    assign last_slot = ({{(LEN_W){1'b0}}, r_slot} == ({{(SLOT_W){1'b0}}, i_len} - 1'b1));

    always_comb begin
        n_slot    = r_slot;
        n_wrapped = r_wrapped;
        if (i_clear) begin
            n_slot    = '0;
            n_wrapped = 1'b0;
        end else if (i_we) begin
            if (last_slot) begin
                n_slot    = '0;
                n_wrapped = 1'b1;
            end else begin
                n_slot = r_slot + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_wrapped <= 1'b0;
            r_rd_live <= 1'b0;
        end else begin
            r_slot    <= n_slot;
            r_wrapped <= n_wrapped;
            if (i_we) begin
                r_rd_live <= r_wrapped;
            end
        end
    end

    assign o_old = r_rd_live ? r_rd_data : '0;

endmodule

// File: hdl/bma_acc.sv
// ----------------------------------------------------------------------------
// bma_acc
// Bit-serial running sum: sum + new - old, LSB first, one bit per cycle.
// A two's complement negation runs alongside to give the magnitude.
// ----------------------------------------------------------------------------
module bma_acc #(
    parameter int SUM_W = 25
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  bma_pkg::t_acc_ctl                     i_ctl,
    input  logic signed [bma_pkg::SAMPLE_W-1:0]   i_new,
    input  logic signed [bma_pkg::SAMPLE_W-1:0]   i_old,
    output logic [SUM_W-1:0]                      o_mag,
    output logic                                  o_sign
);

    logic [SUM_W-1:0]              r_sum;
    logic [SUM_W-1:0]              r_neg;
    logic [bma_pkg::SAMPLE_W-1:0]  r_a;
    logic [bma_pkg::SAMPLE_W-1:0]  r_b;
    logic [1:0]                    r_carry;
    logic                          r_seen;
    logic [2:0]                    bit_sum;

    assign bit_sum = {2'b00, r_sum[0]} + {2'b00, r_a[0]} + {2'b00, ~r_b[0]}
                   + {1'b0, r_carry};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.clear) begin
            r_sum <= '0;
        end else if (i_ctl.shift) begin
            r_sum <= {bit_sum[0], r_sum[SUM_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a     <= i_new;
            r_b     <= i_old;
            r_carry <= 2'd1;
            r_seen  <= 1'b0;
        end else if (i_ctl.shift) begin
            r_a     <= {r_a[bma_pkg::SAMPLE_W-1], r_a[bma_pkg::SAMPLE_W-1:1]};
            r_b     <= {r_b[bma_pkg::SAMPLE_W-1], r_b[bma_pkg::SAMPLE_W-1:1]};
            r_carry <= bit_sum[2:1];
            r_seen  <= r_seen | bit_sum[0];
            r_neg   <= {bit_sum[0] ^ r_seen, r_neg[SUM_W-1:1]};
        end
    end

    assign o_sign = r_sum[SUM_W-1];
    assign o_mag  = o_sign ? r_neg : r_sum;

endmodule

// File: hdl/bma_div.sv
// ----------------------------------------------------------------------------
// bma_div
// Restoring serial divider, one quotient bit per cycle, with sign restore
// and clipping to the signed 16-bit range.
// ----------------------------------------------------------------------------
module bma_div #(
    parameter int SUM_W = 25,
    parameter int LEN_W = 9
) (
    input  logic                                  i_clk,
    input  bma_pkg::t_div_ctl                     i_ctl,
    input  logic [SUM_W-1:0]                      i_mag,
    input  logic                                  i_sign,
    input  logic [LEN_W-1:0]                      i_len,
    output logic signed [bma_pkg::SAMPLE_W-1:0]   o_result
);

    localparam int Q_W = bma_pkg::SAMPLE_W + 1;

    logic [SUM_W-1:0] r_dvd;
    logic [LEN_W-1:0] r_rem;
    logic [Q_W-1:0]   r_quo;
    logic             r_ovf;
    logic             r_neg;
    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   diff;
    logic             ge;
    logic             clip_pos;
    logic             clip_neg;

    assign trial = {r_rem, r_dvd[SUM_W-1]};
    assign diff  = trial - {1'b0, i_len};
    assign ge    = (trial >= {1'b0, i_len});

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_dvd <= i_mag;
            r_rem <= '0;
            r_quo <= '0;
            r_ovf <= 1'b0;
            r_neg <= i_sign;
        end else if (i_ctl.shift) begin
            r_dvd <= {r_dvd[SUM_W-2:0], 1'b0};
            r_rem <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
            r_quo <= {r_quo[Q_W-2:0], ge};
            r_ovf <= r_ovf | r_quo[Q_W-1];
        end
    end

    assign clip_pos = r_ovf || r_quo[Q_W-1] || r_quo[Q_W-2];
    assign clip_neg = r_ovf || r_quo[Q_W-1]
                   || (r_quo[Q_W-2] && (r_quo[Q_W-3:0] != '0));

    always_comb begin
        if (r_neg) begin
            if (clip_neg) begin
                o_result = {1'b1, {(bma_pkg::SAMPLE_W-1){1'b0}}};
            end else begin
                o_result = ~r_quo[bma_pkg::SAMPLE_W-1:0] + 1'b1;
            end
        end else begin
            if (clip_pos) begin
                o_result = {1'b0, {(bma_pkg::SAMPLE_W-1){1'b1}}};
            end else begin
                o_result = r_quo[bma_pkg::SAMPLE_W-1:0];
            end
        end
    end

endmodule

// File: test/tb_boxcar_moving_average_core.sv
// ----------------------------------------------------------------------------
// tb_boxcar_moving_average_core
// Self-checking bench for the boxcar moving average core. A short table of
// directed samples and window lengths runs first, then random phases with
// varying window lengths, sender gaps and receiver stalls. Every average is
// predicted from a local model of the window history and running sum, or
// taken from the table where a row gives it, and compared in order.
// ----------------------------------------------------------------------------
module tb_boxcar_moving_average_core;

    localparam int MAX_LEN       = 256;
    localparam int SETTLE_CYCLES = 60;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 250;
    localparam int N_ROWS        = 26;

    typedef enum logic {ROW_SAMPLE, ROW_LENGTH} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [15:0]        value;
        bit                 known;
        logic signed [15:0] avg;
    } t_dir_row;

    logic                                i_clk           = 1'b0;
    logic                                i_rst_n         = 1'b0;
    logic                                i_in_valid      = 1'b0;
    logic                                o_in_ready;
    logic signed [bma_pkg::SAMPLE_W-1:0] i_sample_in     = '0;
    logic                                o_out_valid;
    logic                                i_out_ready     = 1'b0;
    logic signed [bma_pkg::SAMPLE_W-1:0] o_average_out;
    logic                                i_cfg_valid     = 1'b0;
    logic                                o_cfg_ready;
    logic [bma_pkg::CFG_W-1:0]           i_window_length = '0;

    logic signed [15:0] hist_mem [MAX_LEN];
    longint             win_sum;
    int                 win_slot;
    int                 win_len;

    logic signed [15:0] avg_due_q [$];
    int                 mismatch_cnt = 0;
    int                 tx_idle_pct  = 0;
    int                 rx_stall_pct = 0;
    int                 rx_hold      = 0;
    int                 run_left     = 0;
    logic signed [15:0] run_val      = '0;

    t_dir_row dir_rows [0:N_ROWS-1] = '{
        '{ROW_SAMPLE, 16'h7FFF, 1'b1, 16'sh7FFF},
        '{ROW_SAMPLE, 16'h8000, 1'b1, 16'sh8000},
        '{ROW_SAMPLE, 16'h0000, 1'b1, 16'sh0000},
        '{ROW_SAMPLE, 16'hFFFF, 1'b1, 16'shFFFF},
        '{ROW_SAMPLE, 16'h0001, 1'b1, 16'sh0001},
        '{ROW_LENGTH, 16'h0000, 1'b0, 16'sh0000},   // zero length, raised to 1
        '{ROW_SAMPLE, 16'h5555, 1'b1, 16'sh5555},
        '{ROW_SAMPLE, 16'hAAAA, 1'b1, 16'shAAAA},
        '{ROW_LENGTH, 16'h01FF, 1'b0, 16'sh0000},   // above max, lowered to 256
        '{ROW_SAMPLE, 16'h7FFF, 1'b1, 16'sh007F},
        '{ROW_SAMPLE, 16'h7FFF, 1'b1, 16'sh00FF},
        '{ROW_SAMPLE, 16'h8000, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 16'hFFFF, 1'b0, 16'sh0000},
        '{ROW_LENGTH, 16'h0002, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 16'h8000, 1'b1, 16'shC000},
        '{ROW_SAMPLE, 16'h8000, 1'b1, 16'sh8000},
        '{ROW_SAMPLE, 16'hFFFF, 1'b1, 16'shC000},   // negative sum truncates up
        '{ROW_SAMPLE, 16'h7FFF, 1'b1, 16'sh3FFF},
        '{ROW_SAMPLE, 16'h7FFF, 1'b1, 16'sh7FFF},
        '{ROW_LENGTH, 16'h0101, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 16'hFFFD, 1'b1, 16'sh0000},
        '{ROW_LENGTH, 16'h0003, 1'b0, 16'sh0000},
        '{ROW_SAMPLE, 16'h0001, 1'b1, 16'sh0000},
        '{ROW_SAMPLE, 16'h0001, 1'b1, 16'sh0000},
        '{ROW_SAMPLE, 16'h0001, 1'b1, 16'sh0001},
        '{ROW_SAMPLE, 16'hFFF9, 1'b0, 16'sh0000}
    };

    boxcar_moving_average_core #(
        .MAX_LENGTH(MAX_LEN)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_in    (i_sample_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_average_out  (o_average_out),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_window_length(i_window_length)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // window model
    function automatic void clear_history();
        foreach (hist_mem[i]) hist_mem[i] = '0;
        win_sum  = 0;
        win_slot = 0;
    endfunction

    function automatic void apply_length(input logic [bma_pkg::CFG_W-1:0] v);
        int n;
        n = int'(v);
        if (n < 1) n = 1;
        if (n > MAX_LEN) n = MAX_LEN;
        win_len = n;
        clear_history();
    endfunction

    function automatic logic signed [15:0] next_average(input logic signed [15:0] s);
        longint q;
        int     slot;
        slot = win_slot % win_len;
        win_sum += longint'(s) - longint'(hist_mem[slot]);
        hist_mem[slot] = s;
        win_slot = (slot + 1) % win_len;
        q = win_sum / longint'(win_len);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic logic signed [15:0] pick_sample();
        int v;
        if (run_left == 0 && $urandom_range(0, 39) == 0) begin
            run_left = $urandom_range(1, 300);
            run_val  = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end
        if (run_left > 0) begin
            run_left--;
            return run_val;
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom;
            5, 6:          v = int'($urandom_range(0, 16)) - 8;
            7:             v = 32'h7FFF;
            8:             v = 32'h8000;
            default:       v = $urandom_range(0, 1) ? 32'hFFFF : 32'h0001;
        endcase
        return v[15:0];
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (avg_due_q.size() != 0);
    endtask

    task automatic put_sample(input logic signed [15:0] s, input bit known,
                              input logic signed [15:0] typed_avg);
        logic signed [15:0] model_avg;
        i_in_valid  <= 1'b1;
        i_sample_in <= s;
        do @(posedge i_clk); while (!o_in_ready);
        model_avg = next_average(s);
        avg_due_q.insert(avg_due_q.size(), known ? typed_avg : model_avg);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 70)) @(posedge i_clk);
        end
    endtask

    task automatic set_length(input logic [bma_pkg::CFG_W-1:0] v);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid     <= 1'b1;
        i_window_length <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_length(v);
        i_cfg_valid <= 1'b0;
    endtask

    // receiver: short random stalls with occasional long holds
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold     <= rx_hold - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < rx_stall_pct) begin
            i_out_ready <= 1'b0;
            rx_hold     <= ($urandom_range(0, 7) == 0) ? $urandom_range(8, 120) : 0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : avg_check
        logic signed [15:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (avg_due_q.size() == 0) begin
                report_mismatch($sformatf("average %0d with no sample pending",
                                          o_average_out));
            end else begin
                want = avg_due_q.pop_front();
                if (o_average_out !== want)
                    report_mismatch($sformatf("average got %0d want %0d",
                                              o_average_out, want));
            end
        end
    end

    initial begin : stim
        logic [bma_pkg::CFG_W-1:0] len;
        int                        pause_at;
        apply_length(9'd1);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_LENGTH)
                set_length(dir_rows[r].value[bma_pkg::CFG_W-1:0]);
            else
                put_sample(dir_rows[r].value, dir_rows[r].known, dir_rows[r].avg);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       len = 9'd256;
                1:       len = 9'd1;
                2:       len = 9'($urandom_range(2, 16));
                3:       len = 9'($urandom_range(0, 511));
                4:       len = 9'd255;
                default: len = 9'($urandom_range(17, 300));
            endcase
            set_length(len);
            case (p % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 58; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 58; end
                default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
            endcase
            pause_at = $urandom_range(20, PHASE_ITEMS - 20);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == pause_at) wait_idle();
                put_sample(pick_sample(), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin : watchdog
        #10000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
